// ----- hw/rtl/bcg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcg_pkg
// Shared types and constants for the buffer capacity growth pipeline.
// ----------------------------------------------------------------------------
package bcg_pkg;

  localparam int unsigned CapW    = 64;
  localparam int unsigned StrideW = 32;
  localparam int unsigned NumCells = CapW;

  localparam logic [CapW-1:0] MibOne     = 64'd1048576;
  localparam logic [CapW-1:0] MibSixteen = 64'd16777216;
  localparam logic [CapW-1:0] AllOnes    = '1;

  typedef enum logic [1:0] {
    KIND_KEEP,
    KIND_PLAIN,
    KIND_HEAD,
    KIND_GROW
  } bcg_kind_t;

  typedef struct packed {
    bcg_kind_t           kind;
    logic [CapW-1:0]     current;
    logic [CapW-1:0]     minimum;
    logic [CapW-1:0]     base;
    logic [CapW-1:0]     cap;
    logic [StrideW-1:0]  stride;
    logic [StrideW-1:0]  rem;
  } bcg_cell_t;

endpackage

// ----- hw/rtl/bcg_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcg_cell
// One link of the chain: one remainder bit of base mod stride and one
// saturating doubling step of the growing capacity.
// ----------------------------------------------------------------------------
module bcg_cell
  import bcg_pkg::*;
#(
  parameter int unsigned BIT = 63
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      in_valid,
  input  bcg_cell_t in_data,
  output logic      out_valid,
  output bcg_cell_t out_data
);

  logic [StrideW:0]   shifted;
  logic [StrideW-1:0] rem_next;
  logic [CapW-1:0]    cap_next;
  bcg_cell_t          data_next;

  always_comb begin
    shifted = {in_data.rem, in_data.base[BIT]};
    if (shifted >= {1'b0, in_data.stride}) begin
      rem_next = StrideW'(shifted - {1'b0, in_data.stride});
    end else begin
      rem_next = shifted[StrideW-1:0];
    end
    if (in_data.cap < in_data.minimum) begin
      cap_next = in_data.cap[CapW-1] ? AllOnes : {in_data.cap[CapW-2:0], 1'b0};
    end else begin
      cap_next = in_data.cap;
    end
    data_next     = in_data;
    data_next.rem = rem_next;
    data_next.cap = cap_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= data_next;
    end
  end

endmodule

// ----- hw/rtl/buffer_capacity_growth_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buffer_capacity_growth_core
// Capacity sizing: keep, plain minimum, headroom with stride alignment, or
// saturating geometric doubling.
// ----------------------------------------------------------------------------
// pipeline: two prep stages, 64 chain cells, one output register
// throughput: one transaction per cycle while in_stall is low; the 64-cell chain
// does one remainder bit and one doubling step per cell
// reset: synchronous rst clears all valid bits and the stored growth mode to plain
// ----------------------------------------------------------------------------
module buffer_capacity_growth_core
  import bcg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               growth_mode,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CapW-1:0]    current_capacity,
  input  logic [CapW-1:0]    required_size,
  input  logic [StrideW-1:0] element_stride,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [CapW-1:0]    new_capacity
);

  logic en;
  logic mode;

  logic               s1_valid;
  bcg_kind_t          s1_kind;
  logic [CapW-1:0]    s1_current;
  logic [CapW-1:0]    s1_minimum;
  logic [CapW-1:0]    s1_cap;
  logic [StrideW-1:0] s1_stride;

  logic [CapW-1:0]    minimum_next;
  bcg_kind_t          kind_next;
  logic [CapW-1:0]    cap_next;
  logic [CapW-1:0]    quarter;
  logic [CapW-1:0]    head;
  logic [CapW:0]      head_sum;
  bcg_cell_t          base_next;

  logic      chain_valid [NumCells+1];
  bcg_cell_t chain_data  [NumCells+1];

  bcg_cell_t          last;
  logic [StrideW-1:0] pad;
  logic [CapW:0]      pad_sum;
  logic [CapW-1:0]    head_result;
  logic [CapW-1:0]    result;

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
    end else if (cfg_we) begin
      mode <= growth_mode;
    end
  end

  // stage 1: minimum, case and doubling start
  always_comb begin
    minimum_next = (required_size > {32'd0, element_stride}) ? required_size
                                                             : {32'd0, element_stride};
    cap_next = (current_capacity > {32'd0, element_stride}) ? current_capacity
                                                            : {32'd0, element_stride};
    if (current_capacity == '0) begin
      kind_next = mode ? KIND_HEAD : KIND_PLAIN;
    end else if (current_capacity >= minimum_next) begin
      kind_next = KIND_KEEP;
    end else begin
      kind_next = KIND_GROW;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_kind    <= kind_next;
      s1_current <= current_capacity;
      s1_minimum <= minimum_next;
      s1_cap     <= cap_next;
      s1_stride  <= element_stride;
    end
  end

  // stage 2: headroom base
  always_comb begin
    quarter = {2'b00, s1_minimum[CapW-1:2]};
    if (quarter < MibOne) begin
      head = MibOne;
    end else if (quarter > MibSixteen) begin
      head = MibSixteen;
    end else begin
      head = quarter;
    end
    head_sum          = {1'b0, s1_minimum} + {1'b0, head};
    base_next.kind    = s1_kind;
    base_next.current = s1_current;
    base_next.minimum = s1_minimum;
    base_next.base    = head_sum[CapW] ? s1_minimum : head_sum[CapW-1:0];
    base_next.cap     = s1_cap;
    base_next.stride  = s1_stride;
    base_next.rem     = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_valid[0] <= 1'b0;
    end else if (en) begin
      chain_valid[0] <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      chain_data[0] <= base_next;
    end
  end

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    bcg_cell #(
      .BIT(NumCells - 1 - i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (chain_valid[i]),
      .in_data  (chain_data[i]),
      .out_valid(chain_valid[i+1]),
      .out_data (chain_data[i+1])
    );
  end

  // alignment and result select
  always_comb begin
    last    = chain_data[NumCells];
    pad     = last.stride - last.rem;
    pad_sum = {1'b0, last.base} + {33'd0, pad};
    if (last.stride > 32'd1 && last.rem != '0) begin
      head_result = pad_sum[CapW] ? last.minimum : pad_sum[CapW-1:0];
    end else begin
      head_result = last.base;
    end
    case (last.kind)
      KIND_KEEP:  result = last.current;
      KIND_PLAIN: result = last.minimum;
      KIND_HEAD:  result = head_result;
      KIND_GROW:  result = last.cap;
      default:    result = last.minimum;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= chain_valid[NumCells];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      new_capacity <= result;
    end
  end

  // checks
  a_grow_reaches_min: assert property (@(posedge clk) disable iff (rst)
    chain_valid[NumCells] && last.kind == KIND_GROW |-> last.cap >= last.minimum)
    else $error("doubling chain ended below minimum");

  a_head_reaches_min: assert property (@(posedge clk) disable iff (rst)
    chain_valid[NumCells] && last.kind == KIND_HEAD |-> head_result >= last.minimum)
    else $error("headroom result below minimum");

  a_stall_back: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while output held");

  a_out_follows_chain: assert property (@(posedge clk) disable iff (rst)
    en && chain_valid[NumCells] |=> out_valid)
    else $error("chain transaction lost at output");

endmodule
